FILE: sv/kpc_pkg.sv
package kpc_pkg;

   localparam int K_MAX_DEFAULT        = 10;
   localparam int FILE_ID_BITS_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT   = 16;

   localparam int LEN_BITS        = 4;
   localparam int SYMBOL_BITS     = 8;
   localparam int FILE_FIELD_BITS = 16;
   localparam int ADDR_FIELD_BITS = 20;
   localparam int VALUE_BITS      = 20;
   localparam int OUT_COUNT_BITS  = 16;

   localparam logic [LEN_BITS-1:0] LEN_RESET = 4'd10;

   localparam int REQ_SYMBOL_LSB = 0;
   localparam int REQ_SOF_POS    = REQ_SYMBOL_LSB + SYMBOL_BITS;
   localparam int REQ_FILE_LSB   = REQ_SOF_POS + 1;
   localparam int REQ_RES_POS    = REQ_FILE_LSB + FILE_FIELD_BITS;
   localparam int REQ_ADDR_LSB   = REQ_RES_POS + 1;
   localparam int REQ_USED_BITS  = REQ_ADDR_LSB + ADDR_FIELD_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;

   localparam int RSP_VALUE_LSB  = 0;
   localparam int RSP_FIRST_POS  = RSP_VALUE_LSB + VALUE_BITS;
   localparam int RSP_RES_LSB    = RSP_FIRST_POS + 1;
   localparam int RSP_SUS_LSB    = RSP_RES_LSB + OUT_COUNT_BITS;
   localparam int RSP_LAST_LSB   = RSP_SUS_LSB + OUT_COUNT_BITS;
   localparam int RSP_USED_BITS  = RSP_LAST_LSB + FILE_FIELD_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RSP_USED_BITS;

   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic [SYMBOL_BITS-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [SYMBOL_BITS-1:0] CHAR_UC_C    = 8'h43;
   localparam logic [SYMBOL_BITS-1:0] CHAR_UC_G    = 8'h47;
   localparam logic [SYMBOL_BITS-1:0] CHAR_UC_T    = 8'h54;
   localparam logic [SYMBOL_BITS-1:0] CHAR_LC_C    = 8'h63;
   localparam logic [SYMBOL_BITS-1:0] CHAR_LC_G    = 8'h67;
   localparam logic [SYMBOL_BITS-1:0] CHAR_LC_T    = 8'h74;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_COUNT,
      KIND_READ
   } kpc_kind_type;

   typedef struct packed {
      logic                      kmer_valid;
      logic [RSP_TDATA_BITS-1:0] tdata;
   } kpc_result_type;

   function automatic logic [1:0] base_code(input logic [SYMBOL_BITS-1:0] c);
      logic [1:0] code;
      case (c) inside
         CHAR_UC_C, CHAR_LC_C: code = 2'd1;
         CHAR_UC_G, CHAR_LC_G: code = 2'd2;
         CHAR_UC_T, CHAR_LC_T: code = 2'd3;
         default:              code = 2'd0;
      endcase
      return code;
   endfunction

endpackage

FILE: sv/kpc_window.sv
module kpc_window
   import kpc_pkg::*;
#(
   parameter int K_MAX = K_MAX_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [LEN_BITS-1:0]        csr_data,
   input  logic                       accept,
   input  logic                       func,
   input  logic [SYMBOL_BITS-1:0]     symbol,
   input  logic                       start_of_file,
   input  logic [ADDR_FIELD_BITS-1:0] read_address,
   output logic [2*K_MAX-1:0]         lk_addr,
   output logic [VALUE_BITS-1:0]      lk_value,
   output kpc_kind_type               lk_kind
);

   localparam int WIN_BITS  = 2 * K_MAX;
   localparam int FILL_BITS = $clog2(K_MAX + 1);
   localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(K_MAX);

   logic [LEN_BITS-1:0]  kmer_length_ff;
   logic [WIN_BITS-1:0]  window_ff, window_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   logic [FILL_BITS-1:0] k_eff;
   logic [WIN_BITS-1:0]  kmask;
   logic [WIN_BITS-1:0]  win_base, win_shift;
   logic [FILL_BITS-1:0] fill_base, fill_inc;

   always_comb begin
      if (kmer_length_ff == '0) begin
         k_eff = FILL_BITS'(1);
      end else if (int'(kmer_length_ff) > K_MAX) begin
         k_eff = FILL_MAX;
      end else begin
         k_eff = FILL_BITS'(kmer_length_ff);
      end
      for (int i = 0; i < WIN_BITS; i++) begin
         kmask[i] = (i < 2 * int'(k_eff));
      end
   end

   always_comb begin
      win_base  = start_of_file ? '0 : window_ff;
      fill_base = start_of_file ? '0 : fill_ff;
      win_shift = WIN_BITS'({win_base, base_code(symbol)}) & kmask;
      fill_inc  = (fill_base < FILL_MAX) ? fill_base + 1'b1 : fill_base;

      window_in = window_ff;
      fill_in   = fill_ff;
      lk_kind   = KIND_PLAIN;
      lk_addr   = win_shift;
      lk_value  = VALUE_BITS'(win_shift);
      if (func) begin
         lk_kind  = KIND_READ;
         lk_addr  = WIN_BITS'(read_address);
         lk_value = VALUE_BITS'(WIN_BITS'(read_address));
      end else if (symbol == CHAR_NEWLINE) begin
         lk_value = VALUE_BITS'(win_base & kmask);
         if (accept) begin
            window_in = win_base;
            fill_in   = fill_base;
         end
      end else begin
         if (fill_inc >= k_eff) begin
            lk_kind = KIND_COUNT;
         end
         if (accept) begin
            window_in = win_shift;
            fill_in   = fill_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= LEN_RESET;
         window_ff      <= '0;
         fill_ff        <= '0;
      end else begin
         if (csr_valid) begin
            kmer_length_ff <= csr_data;
         end
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: sv/kpc_table.sv
module kpc_table
   import kpc_pkg::*;
#(
   parameter int K_MAX        = K_MAX_DEFAULT,
   parameter int FILE_ID_BITS = FILE_ID_BITS_DEFAULT,
   parameter int COUNT_BITS   = COUNT_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [2*K_MAX-1:0]         lk_addr,
   input  logic [VALUE_BITS-1:0]      lk_value,
   input  kpc_kind_type               lk_kind,
   input  logic [FILE_FIELD_BITS-1:0] file_id,
   input  logic                       is_resistant,
   output logic                       busy,
   output logic                       s1_valid,
   output kpc_result_type             push_result
);

   localparam int WIN_BITS   = 2 * K_MAX;
   localparam int ENTRY_BITS = 2 * COUNT_BITS + FILE_ID_BITS;
   localparam int SUS_LSB    = COUNT_BITS;
   localparam int LAST_LSB   = 2 * COUNT_BITS;

   logic [ENTRY_BITS-1:0] entry_mem [0:(64'd1 << WIN_BITS) - 1];

   logic                  clearing_ff;
   logic [WIN_BITS-1:0]   clr_addr_ff;
   logic [ENTRY_BITS-1:0] rd_data_ff;

   logic                       s1_valid_ff;
   kpc_kind_type               s1_kind_ff;
   logic [WIN_BITS-1:0]        s1_addr_ff;
   logic [VALUE_BITS-1:0]      s1_value_ff;
   logic [FILE_FIELD_BITS-1:0] s1_fid_ff;
   logic                       s1_res_ff;

   logic                  fwd_valid_ff;
   logic [WIN_BITS-1:0]   fwd_addr_ff;
   logic [ENTRY_BITS-1:0] fwd_data_ff;

   logic [ENTRY_BITS-1:0]   entry, new_entry, mem_wd;
   logic [WIN_BITS-1:0]     mem_wa;
   logic                    mem_we, upd_we;
   logic [COUNT_BITS-1:0]   ent_res, ent_sus, new_res, new_sus, out_res, out_sus;
   logic [FILE_ID_BITS-1:0] ent_last, new_last, out_last, fid_cut;
   logic                    fresh, do_count, out_valid, out_first;

   assign busy     = clearing_ff;
   assign s1_valid = s1_valid_ff;

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         entry = fwd_data_ff;
      end else begin
         entry = rd_data_ff;
      end
      ent_res  = entry[COUNT_BITS-1:0];
      ent_sus  = entry[SUS_LSB +: COUNT_BITS];
      ent_last = entry[LAST_LSB +: FILE_ID_BITS];
      fresh    = (ent_res == '0) && (ent_sus == '0);
      fid_cut  = FILE_ID_BITS'(s1_fid_ff);
      do_count = fresh || (ent_last != fid_cut);

      new_res  = ent_res;
      new_sus  = ent_sus;
      new_last = ent_last;
      if (do_count) begin
         if (s1_res_ff) begin
            if (ent_res != {COUNT_BITS{1'b1}}) begin
               new_res = ent_res + 1'b1;
            end
         end else begin
            if (ent_sus != {COUNT_BITS{1'b1}}) begin
               new_sus = ent_sus + 1'b1;
            end
         end
         new_last = fid_cut;
      end
      new_entry = {new_last, new_sus, new_res};

      upd_we    = 1'b0;
      out_valid = 1'b0;
      out_first = 1'b0;
      out_res   = '0;
      out_sus   = '0;
      out_last  = '0;
      unique case (s1_kind_ff)
         KIND_COUNT: begin
            upd_we    = s1_valid_ff && do_count;
            out_valid = 1'b1;
            out_first = fresh;
            out_res   = new_res;
            out_sus   = new_sus;
            out_last  = new_last;
         end
         KIND_READ: begin
            out_valid = 1'b1;
            out_first = fresh;
            out_res   = ent_res;
            out_sus   = ent_sus;
            out_last  = ent_last;
         end
         default: begin
            out_valid = 1'b0;
         end
      endcase

      push_result.kmer_valid = out_valid;
      push_result.tdata = {{RSP_PAD_BITS{1'b0}},
                           FILE_FIELD_BITS'(out_last),
                           OUT_COUNT_BITS'(out_sus),
                           OUT_COUNT_BITS'(out_res),
                           out_first,
                           s1_value_ff};

      mem_we = clearing_ff || upd_we;
      mem_wa = clearing_ff ? clr_addr_ff : s1_addr_ff;
      mem_wd = clearing_ff ? '0 : new_entry;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= entry_mem[lk_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == {WIN_BITS{1'b1}}) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff  <= accept;
         fwd_valid_ff <= upd_we;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= new_entry;
      if (accept) begin
         s1_kind_ff  <= lk_kind;
         s1_addr_ff  <= lk_addr;
         s1_value_ff <= lk_value;
         s1_fid_ff   <= file_id;
         s1_res_ff   <= is_resistant;
      end
   end

endmodule

FILE: sv/kpc_out_fifo.sv
module kpc_out_fifo
   import kpc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  kpc_result_type            push_result,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      rsp_tuser,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic [FIFO_CNT_BITS-1:0]  fill_level
);

   localparam logic [FIFO_PTR_BITS-1:0] PTR_LAST = FIFO_PTR_BITS'(FIFO_DEPTH - 1);

   kpc_result_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [FIFO_CNT_BITS-1:0]  count_ff, count_in;
   logic                      pop;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = slot_ff[head_ff].kmer_valid;
   assign rsp_tdata  = slot_ff[head_ff].tdata;
   assign fill_level = count_ff;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
         count_in = count_in - 1'b1;
      end
      if (push_valid) begin
         tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
         count_in = count_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[tail_ff] <= push_result;
      end
   end

endmodule

FILE: sv/kmer_presence_counter.sv
// An item taken at a rising edge is registered into the table stage along with
// its table read; its result is then written into the output queue on rsp_tdata.
// Throughput: one item per cycle while the table is not being swept and the
// output queue has room; the table read-modify-write is forwarded between
// neighboring items, and a three-entry output queue absorbs stalls.
// Reset is synchronous: k returns to 10, window and fill clear, and the table
// is then swept to zero, one entry per cycle over every address, during which req_tready stays low.
module kmer_presence_counter
   import kpc_pkg::*;
#(
   parameter int K_MAX        = K_MAX_DEFAULT,
   parameter int FILE_ID_BITS = FILE_ID_BITS_DEFAULT,
   parameter int COUNT_BITS   = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [LEN_BITS-1:0]       csr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tuser,  // func
   // symbol, start_of_file, file_id, is_resistant, read_address
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      rsp_tuser,  // kmer_valid
   // kmer_value, first_seen, res_count, sus_count, last_file
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   logic                     accept, busy, s1_valid;
   logic [2*K_MAX-1:0]       lk_addr;
   logic [VALUE_BITS-1:0]    lk_value;
   kpc_kind_type             lk_kind;
   kpc_result_type           push_result;
   logic [FIFO_CNT_BITS-1:0] fill_level;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy &&
                       ((FIFO_CNT_BITS + 1)'(fill_level) + (FIFO_CNT_BITS + 1)'(s1_valid)
                        < (FIFO_CNT_BITS + 1)'(FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   kpc_window #(
      .K_MAX(K_MAX)
   ) u_window (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_data(csr_data),
      .accept(accept),
      .func(req_tuser),
      .symbol(req_tdata[REQ_SYMBOL_LSB +: SYMBOL_BITS]),
      .start_of_file(req_tdata[REQ_SOF_POS]),
      .read_address(req_tdata[REQ_ADDR_LSB +: ADDR_FIELD_BITS]),
      .lk_addr(lk_addr),
      .lk_value(lk_value),
      .lk_kind(lk_kind)
   );

   kpc_table #(
      .K_MAX(K_MAX),
      .FILE_ID_BITS(FILE_ID_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_table (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .lk_addr(lk_addr),
      .lk_value(lk_value),
      .lk_kind(lk_kind),
      .file_id(req_tdata[REQ_FILE_LSB +: FILE_FIELD_BITS]),
      .is_resistant(req_tdata[REQ_RES_POS]),
      .busy(busy),
      .s1_valid(s1_valid),
      .push_result(push_result)
   );

   kpc_out_fifo u_out_fifo (
      .clock(clock),
      .reset(reset),
      .push_valid(s1_valid),
      .push_result(push_result),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .fill_level(fill_level)
   );

endmodule

FILE: sv/kpc_checker.sv
module kpc_checker
   import kpc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic                      rsp_tuser,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   // The table sweep starts at reset, so nothing is taken or shown right after it.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("item taken or result shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A result with no counted k-mer (a window that is not full, or a newline) carries no table entry.
   a_partial_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[RSP_FIRST_POS] == 1'b0 &&
         rsp_tdata[RSP_RES_LSB +: OUT_COUNT_BITS] == '0 &&
         rsp_tdata[RSP_SUS_LSB +: OUT_COUNT_BITS] == '0 &&
         rsp_tdata[RSP_LAST_LSB +: FILE_FIELD_BITS] == '0)
      else $error("partial window result carries entry data");

   // An entry seen before has left zero and never returns to it.
   a_seen_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && !rsp_tdata[RSP_FIRST_POS] |->
         rsp_tdata[RSP_RES_LSB +: OUT_COUNT_BITS] != '0 ||
         rsp_tdata[RSP_SUS_LSB +: OUT_COUNT_BITS] != '0)
      else $error("known entry reported with zero counts");

endmodule

bind kmer_presence_counter kpc_checker u_kpc_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tuser(rsp_tuser),
   .rsp_tdata(rsp_tdata)
);

FILE: sim/kmer_presence_counter_tb.sv
`timescale 1ns / 1ps

module kmer_presence_counter_tb;
   import kpc_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int LIMIT_CYCLES = 5_000_000;
   localparam int DRAIN_CYCLES = 6;
   localparam int TMPL_COUNT   = 8;
   localparam int TMPL_LEN     = 48;
   localparam int PHASE_ITEMS  = 145;
   localparam int PHASE_K [10] = '{1, 2, 3, 0, 15, 10, 4, 6, 8, 12};

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic [SYMBOL_BITS-1:0] CHAR_UC_A = 8'h41;
   localparam logic [SYMBOL_BITS-1:0] CHAR_LC_A = 8'h61;
   localparam logic [SYMBOL_BITS-1:0] CHAR_BAD  = 8'h4E;

   typedef struct packed {
      logic                       func;
      logic [SYMBOL_BITS-1:0]     symbol;
      logic                       sof;
      logic [FILE_FIELD_BITS-1:0] file_id;
      logic                       resistant;
      logic [ADDR_FIELD_BITS-1:0] addr;
   } kpc_in_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]      value;
      logic                       valid;
      logic                       first;
      logic [OUT_COUNT_BITS-1:0]  res;
      logic [OUT_COUNT_BITS-1:0]  sus;
      logic [FILE_FIELD_BITS-1:0] last;
   } kmer_report_type;

   typedef struct packed {
      logic [OUT_COUNT_BITS-1:0]  res;
      logic [OUT_COUNT_BITS-1:0]  sus;
      logic [FILE_FIELD_BITS-1:0] last;
   } kmer_entry_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [LEN_BITS-1:0]       csr_data   = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic                      req_tuser  = 1'b0;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      rsp_tuser;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   // Predictor state.
   logic [LEN_BITS-1:0]   kmer_len = LEN_RESET;
   logic [VALUE_BITS-1:0] window   = '0;
   logic [LEN_BITS-1:0]   fill     = '0;
   kmer_entry_type        count_table [bit [VALUE_BITS-1:0]];

   kmer_report_type       kmer_reports_due [$];
   logic [VALUE_BITS-1:0] seen_kmers [$];
   logic [1:0]            templates [TMPL_COUNT][TMPL_LEN];

   bit          idle_on         = 1'b1;
   bit          rsp_holding     = 1'b0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned cycle_count     = 0;
   int unsigned failures        = 0;
   int unsigned n_results       = 0;
   int unsigned n_pushes        = 0;
   int unsigned n_reads         = 0;
   int unsigned n_counted       = 0;
   int unsigned n_files         = 0;
   int unsigned peak_res        = 0;
   int unsigned peak_sus        = 0;
   logic [FILE_FIELD_BITS-1:0] last_fid = 16'h0001;

   kmer_presence_counter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  kmer_reports_due.size());
         $display("** kmer_presence_counter: FAILED **");
         $finish;
      end
   end

   function automatic kmer_report_type count_kmer(input kpc_in_type it);
      kmer_report_type       o;
      kmer_entry_type        e;
      int unsigned           k;
      logic [VALUE_BITS-1:0] kmask;
      logic [1:0]            code;
      logic                  fresh;
      o = '0;
      k = (kmer_len == '0) ? 1 :
          (int'(kmer_len) > K_MAX_DEFAULT) ? K_MAX_DEFAULT : int'(kmer_len);
      kmask = {VALUE_BITS{1'b1}} >> (2 * (K_MAX_DEFAULT - k));
      if (it.func == FUNC_READ) begin
         e = count_table.exists(it.addr) ? count_table[it.addr] : '0;
         o.value = it.addr;
         o.valid = 1'b1;
         o.first = (e.res == 0) && (e.sus == 0);
         o.res = e.res;
         o.sus = e.sus;
         o.last = e.last;
         return o;
      end
      if (it.sof) begin
         window = '0;
         fill = '0;
      end
      if (it.symbol == CHAR_NEWLINE) begin
         o.value = window & kmask;
         return o;
      end
      case (it.symbol)
         CHAR_UC_C, CHAR_LC_C: code = 2'd1;
         CHAR_UC_G, CHAR_LC_G: code = 2'd2;
         CHAR_UC_T, CHAR_LC_T: code = 2'd3;
         default:              code = 2'd0;
      endcase
      window = ((window << 2) | VALUE_BITS'(code)) & kmask;
      if (fill < K_MAX_DEFAULT) fill = fill + 1'b1;
      o.value = window;
      if (fill < k) return o;
      e = count_table.exists(window) ? count_table[window] : '0;
      fresh = (e.res == 0) && (e.sus == 0);
      if (fresh || e.last != it.file_id) begin
         if (it.resistant) begin
            if (e.res != '1) e.res = e.res + 1'b1;
         end else begin
            if (e.sus != '1) e.sus = e.sus + 1'b1;
         end
         e.last = it.file_id;
         count_table[window] = e;
      end
      if (fresh) begin
         seen_kmers = {seen_kmers, window};
         if (seen_kmers.size() > 64) void'(seen_kmers.pop_front());
      end
      o.valid = 1'b1;
      o.first = fresh;
      o.res = e.res;
      o.sus = e.sus;
      o.last = e.last;
      return o;
   endfunction

   always @(posedge clock) begin : monitor
      kpc_in_type      it;
      kmer_report_type want;
      kmer_report_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) kmer_len = csr_data;
         if (req_tvalid && req_tready) begin
            it.func = req_tuser;
            it.symbol = req_tdata[REQ_SYMBOL_LSB +: SYMBOL_BITS];
            it.sof = req_tdata[REQ_SOF_POS];
            it.file_id = req_tdata[REQ_FILE_LSB +: FILE_FIELD_BITS];
            it.resistant = req_tdata[REQ_RES_POS];
            it.addr = req_tdata[REQ_ADDR_LSB +: ADDR_FIELD_BITS];
            want = count_kmer(it);
            kmer_reports_due = {kmer_reports_due, want};
            if (it.func == FUNC_READ) begin
               n_reads++;
            end else begin
               n_pushes++;
               if (it.sof) n_files++;
               if (want.valid) n_counted++;
               if (want.res > peak_res) peak_res = 32'(want.res);
               if (want.sus > peak_sus) peak_sus = 32'(want.sus);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[RSP_VALUE_LSB +: VALUE_BITS];
            got.valid = rsp_tuser;
            got.first = rsp_tdata[RSP_FIRST_POS];
            got.res = rsp_tdata[RSP_RES_LSB +: OUT_COUNT_BITS];
            got.sus = rsp_tdata[RSP_SUS_LSB +: OUT_COUNT_BITS];
            got.last = rsp_tdata[RSP_LAST_LSB +: FILE_FIELD_BITS];
            n_results++;
            if (kmer_reports_due.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("Result %0d arrived with no item awaiting it: value=%05h valid=%0d",
                           n_results, got.value, got.valid);
            end else begin
               want = kmer_reports_due.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("Mismatch on result %0d:", n_results);
                     $display("  expected value=%05h valid=%0d first=%0d res=%0d sus=%0d last=%0d",
                              want.value, want.valid, want.first, want.res, want.sus,
                              want.last);
                     $display("  actual   value=%05h valid=%0d first=%0d res=%0d sus=%0d last=%0d",
                              got.value, got.valid, got.first, got.res, got.sus, got.last);
                  end
               end
            end
         end
      end
   end

   function automatic int unsigned idle_cycles();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SYMBOL_BITS-1:0] base_char(input logic [1:0] code,
                                                        input bit lower);
      case (code)
         2'd0:    return lower ? CHAR_LC_A : CHAR_UC_A;
         2'd1:    return lower ? CHAR_LC_C : CHAR_UC_C;
         2'd2:    return lower ? CHAR_LC_G : CHAR_UC_G;
         default: return lower ? CHAR_LC_T : CHAR_UC_T;
      endcase
   endfunction

   function automatic logic [SYMBOL_BITS-1:0] random_symbol();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 90) return base_char(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      if (r < 95) return CHAR_NEWLINE;
      return SYMBOL_BITS'($urandom_range(0, 255));
   endfunction

   // The response side stalls at random, or holds off for a requested stretch.
   initial begin : receiver
      int unsigned stall;
      int unsigned run;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            rsp_holding = 1'b1;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
            rsp_holding = 1'b0;
         end else begin
            stall = idle_cycles();
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clock);
         end
      end
   end

   task automatic send_item(input kpc_in_type it);
      int unsigned               gap;
      logic [REQ_TDATA_BITS-1:0] d;
      gap = idle_cycles();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      d = '0;
      d[REQ_SYMBOL_LSB +: SYMBOL_BITS] = it.symbol;
      d[REQ_SOF_POS] = it.sof;
      d[REQ_FILE_LSB +: FILE_FIELD_BITS] = it.file_id;
      d[REQ_RES_POS] = it.resistant;
      d[REQ_ADDR_LSB +: ADDR_FIELD_BITS] = it.addr;
      req_tvalid <= 1'b1;
      req_tuser <= it.func;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic push_symbol(input logic [SYMBOL_BITS-1:0] sym, input logic sof,
                              input logic [FILE_FIELD_BITS-1:0] fid, input logic res);
      kpc_in_type it;
      it.func = FUNC_PUSH;
      it.symbol = sym;
      it.sof = sof;
      it.file_id = fid;
      it.resistant = res;
      it.addr = ADDR_FIELD_BITS'($urandom());
      send_item(it);
   endtask

   task automatic read_entry(input logic [ADDR_FIELD_BITS-1:0] addr);
      kpc_in_type it;
      it.func = FUNC_READ;
      it.symbol = SYMBOL_BITS'($urandom());
      it.sof = 1'($urandom());
      it.file_id = FILE_FIELD_BITS'($urandom());
      it.resistant = 1'($urandom());
      it.addr = addr;
      send_item(it);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (kmer_reports_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_kmer_length(input logic [LEN_BITS-1:0] len);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      write_kmer_length(4'd2);
      // The newline falls inside the first window and must not advance it.
      push_symbol(CHAR_UC_C, 1'b1, 16'h0001, 1'b1);
      push_symbol(CHAR_NEWLINE, 1'b0, 16'h0001, 1'b1);
      push_symbol(CHAR_LC_G, 1'b0, 16'h0001, 1'b1);
      push_symbol(CHAR_UC_C, 1'b0, 16'h0001, 1'b1);
      push_symbol(CHAR_UC_G, 1'b0, 16'h0001, 1'b1);
      push_symbol(CHAR_BAD, 1'b0, 16'h0001, 1'b1);
      push_symbol(CHAR_LC_A, 1'b0, 16'h0001, 1'b1);
      push_symbol(CHAR_LC_T, 1'b0, 16'h0001, 1'b1);
      push_symbol(CHAR_UC_T, 1'b0, 16'h0001, 1'b1);
      push_symbol(8'hFF, 1'b0, 16'h0001, 1'b1);
      push_symbol(8'h00, 1'b0, 16'h0001, 1'b1);
      // File number zero counts a k-mer once, then ignores its repeats.
      push_symbol(CHAR_LC_C, 1'b1, 16'h0000, 1'b0);
      push_symbol(CHAR_UC_G, 1'b0, 16'h0000, 1'b0);
      push_symbol(CHAR_UC_C, 1'b0, 16'h0000, 1'b0);
      push_symbol(CHAR_UC_G, 1'b0, 16'h0000, 1'b0);
      push_symbol(CHAR_LC_C, 1'b1, 16'hFFFF, 1'b1);
      push_symbol(CHAR_LC_G, 1'b0, 16'hFFFF, 1'b1);
      push_symbol(CHAR_NEWLINE, 1'b1, 16'h0005, 1'b0);
      read_entry(20'h00006);
      read_entry(20'hFFFFF);
      read_entry(20'h00000);
      push_symbol(CHAR_LC_T, 1'b0, 16'h0005, 1'b0);
      push_symbol(CHAR_UC_G, 1'b0, 16'h0005, 1'b0);
   endtask

   task automatic test_length_change();
      int i;
      write_kmer_length(4'd10);
      for (i = 0; i < 12; i++) push_symbol(random_symbol(), i == 0, 16'h1234, 1'b0);
      write_kmer_length(4'd3);
      for (i = 0; i < 5; i++) push_symbol(random_symbol(), 1'b0, 16'h1234, 1'b0);
      write_kmer_length(4'd15);
      for (i = 0; i < 3; i++) push_symbol(random_symbol(), 1'b0, 16'h1234, 1'b0);
      push_symbol(CHAR_NEWLINE, 1'b0, 16'h1234, 1'b0);
      write_kmer_length(4'd0);
      for (i = 0; i < 3; i++) push_symbol(random_symbol(), 1'b0, 16'h1234, 1'b1);
      write_kmer_length(4'd1);
      for (i = 0; i < 2; i++) push_symbol(random_symbol(), 1'b0, 16'h4321, 1'b1);
   endtask

   task automatic test_backpressure();
      int                         i;
      logic [FILE_FIELD_BITS-1:0] fid;
      write_kmer_length(4'd4);
      idle_on = 1'b0;
      fid = FILE_FIELD_BITS'($urandom());
      rsp_hold_cycles = 400;
      wait (rsp_holding);
      for (i = 0; i < 64; i++) push_symbol(random_symbol(), i == 0, fid, 1'b1);
      idle_on = 1'b1;
      drain_results();
   endtask

   task automatic send_file();
      logic [FILE_FIELD_BITS-1:0] fid;
      logic [SYMBOL_BITS-1:0]     sym;
      logic                       res;
      int unsigned                t, start, len, reps, r;
      int                         rep, i;
      r = $urandom_range(0, 99);
      if (r < 10) fid = '0;
      else if (r < 20) fid = '1;
      else if (r < 35) fid = last_fid;
      else fid = FILE_FIELD_BITS'($urandom());
      last_fid = fid;
      res = 1'($urandom_range(0, 1));
      t = $urandom_range(0, TMPL_COUNT - 1);
      start = $urandom_range(0, TMPL_LEN - 1);
      len = $urandom_range(1, 24);
      reps = ($urandom_range(0, 9) == 0) ? 2 : 1;
      for (rep = 0; rep < reps; rep++) begin
         for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) sym = random_symbol();
            else if (r < 7) sym = CHAR_NEWLINE;
            else sym = base_char(templates[t][(start + i) % TMPL_LEN],
                                 1'($urandom_range(0, 1)));
            push_symbol(sym, rep == 0 && i == 0, fid, res);
         end
      end
   endtask

   task automatic test_random_files();
      int          p, t, i;
      int unsigned r, target;
      kpc_in_type  it;
      for (t = 0; t < TMPL_COUNT; t++)
         for (i = 0; i < TMPL_LEN; i++) templates[t][i] = 2'($urandom_range(0, 3));
      for (p = 0; p < 10; p++) begin
         write_kmer_length(LEN_BITS'(PHASE_K[p]));
         idle_on = ($urandom_range(0, 3) != 0);
         target = n_pushes + n_reads + PHASE_ITEMS;
         while (n_pushes + n_reads < target) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               send_file();
            end else if (r < 92) begin
               if (seen_kmers.size() != 0 && $urandom_range(0, 2) != 0)
                  read_entry(seen_kmers[$urandom_range(0, seen_kmers.size() - 1)]);
               else
                  read_entry(ADDR_FIELD_BITS'($urandom()));
            end else begin
               it.func = ($urandom_range(0, 3) == 0) ? FUNC_READ : FUNC_PUSH;
               it.symbol = SYMBOL_BITS'($urandom());
               it.sof = 1'($urandom());
               it.file_id = FILE_FIELD_BITS'($urandom());
               it.resistant = 1'($urandom());
               it.addr = ADDR_FIELD_BITS'($urandom());
               send_item(it);
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_length_change();
      test_backpressure();
      test_random_files();
      drain_results();
      if (kmer_reports_due.size() != 0) begin
         $display("%0d expected results never arrived.", kmer_reports_due.size());
         failures += kmer_reports_due.size();
      end
      $display("Run covered %0d symbol pushes in %0d files (%0d full k-mers) and %0d reads,",
               n_pushes, n_files, n_counted, n_reads);
      $display("k from 0 to 15, peak counts %0d resistant / %0d susceptible, %0d failures.",
               peak_res, peak_sus, failures);
      if (failures == 0) begin
         $display("** kmer_presence_counter: PASSED **");
      end else begin
         $display("** kmer_presence_counter: FAILED **");
      end
      $finish;
   end

endmodule
